### rtl/core/hds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere direction sampler package
// Shared types, widths, stage counts and elaboration-time constant tables.
// ----------------------------------------------------------------------------
package hds_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_L      = 28;               // fraction bits of -log2(u)
   localparam int PHASE_STEPS = SAMPLE_BITS - 2;  // rotations after the quadrant
   localparam int LQ_BITS     = 33;
   localparam int CQ_BITS     = 33;               // cos theta, Q1.32 up to 1.0
   localparam int TRIG_BITS   = 32;               // Q2.30 signed
   localparam int ROOT_BITS   = 32;
   localparam int MSB_BITS    = $clog2(SAMPLE_BITS);
   localparam int EXP_K_BITS  = LQ_BITS - FRAC_L;
   localparam int REM_BITS    = 17;               // divisor e + 256 fits here

   localparam int LOG_LAT   = 1 + FRAC_L;
   localparam int DIV_LAT   = 1 + LQ_BITS;
   localparam int EXP_LAT   = 2 + FRAC_L;
   localparam int SQRT_LAT  = 2 + ROOT_BITS;
   localparam int PHASE_LAT = 1 + 2 * PHASE_STEPS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE          = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DENSITY_POWER = 1'b1;
   localparam logic [15:0] DENSITY_POWER_RESET = 16'd256;

   typedef struct packed {
      logic [15:0] first_uniform;
      logic [15:0] second_uniform;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic [14:0]        dir_y;
      logic signed [15:0] dir_z;
   } rsp_payload_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem_v;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem_v = x;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem_v >= res + bit_v) begin
            rem_v = rem_v - (res + bit_v);
            res   = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // restoring long division, only ever evaluated on constants
   function automatic logic [63:0] divu64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[63:0], n[k]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // factors 2^(-2^-(s+1)) in Q0.32 by repeated square roots of one half
   function automatic logic [FRAC_L-1:0][31:0] exp_table();
      logic [FRAC_L-1:0][31:0] tab;
      logic [63:0] t;
      t = 64'd1 << 31;
      for (int s = 0; s < FRAC_L; s++) begin
         t      = isqrt64(t << 32);
         tab[s] = t[31:0];
      end
      return tab;
   endfunction

   // half-angle cos/sin pairs in Q2.30, coarsest angle first
   function automatic logic [PHASE_STEPS-1:0][31:0] phase_table(input logic want_sin);
      logic [PHASE_STEPS-1:0][31:0] tab;
      logic [63:0] c;
      logic [63:0] s;
      logic [63:0] cn;
      c = isqrt64(64'd1 << 59);
      s = c;
      for (int k = 0; k < PHASE_STEPS; k++) begin
         tab[k] = want_sin ? s[31:0] : c[31:0];
         cn     = isqrt64(((64'd1 << 30) + c) << 29);
         s      = divu64(s << 29, cn);
         c      = cn;
      end
      return tab;
   endfunction

   // right shift rounding half away from zero; sh is always a constant
   function automatic logic signed [63:0] rshift_round(input logic signed [63:0] p,
                                                      input int unsigned sh);
      logic [63:0] m;
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/hds_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler delay line
// Stallable shift register that keeps side data level with the pipeline.
// ----------------------------------------------------------------------------
module hds_delay #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

### rtl/core/hds_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler log2 unit
// Normalises u and squares the mantissa once per stage, one fraction bit each.
// ----------------------------------------------------------------------------
module hds_log2 (
   input  logic                         clock,
   input  logic                         en,
   input  logic [hds_pkg::SAMPLE_BITS-1:0] uniform,
   output logic [hds_pkg::FRAC_L-1:0]   frac,
   output logic [hds_pkg::MSB_BITS-1:0] msb_pos
);

   localparam int N = hds_pkg::FRAC_L;

   logic [31:0]                   mant_ff [N+1];
   logic [31:0]                   mant_in [N+1];
   logic [N-1:0]                  frac_ff [N+1];
   logic [N-1:0]                  frac_in [N+1];
   logic [hds_pkg::MSB_BITS-1:0]  msb_ff  [N+1];
   logic [hds_pkg::MSB_BITS-1:0]  msb_in  [N+1];

   always_comb begin
      logic [hds_pkg::MSB_BITS-1:0] top_bit;
      logic [63:0] sq;
      logic [32:0] sh;
      top_bit = '0;
      for (int b = 0; b < hds_pkg::SAMPLE_BITS; b++) begin
         if (uniform[b]) begin
            top_bit = hds_pkg::MSB_BITS'(b);
         end
      end
      msb_in[0]  = top_bit;
      mant_in[0] = 32'(uniform) << (5'd31 - 5'(top_bit));
      frac_in[0] = '0;
      for (int k = 0; k < N; k++) begin
         sq = mant_ff[k] * mant_ff[k];
         sh = sq[63:31];
         msb_in[k+1] = msb_ff[k];
         // mantissa reached 2.0: renormalise and emit a one
         if (sh[32]) begin
            mant_in[k+1] = sh[32:1];
            frac_in[k+1] = frac_ff[k] | (N'(1) << (N - 1 - k));
         end else begin
            mant_in[k+1] = sh[31:0];
            frac_in[k+1] = frac_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant_ff <= mant_in;
         frac_ff <= frac_in;
         msb_ff  <= msb_in;
      end
   end

   assign frac    = frac_ff[N];
   assign msb_pos = msb_ff[N];

endmodule

### rtl/core/hds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler exponent divider
// Pipelined restoring division (L * 256) / (e + 256), one quotient bit a stage.
// ----------------------------------------------------------------------------
module hds_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [hds_pkg::LQ_BITS-1:0] log_val,
   input  logic [15:0]                 density_power,
   output logic [hds_pkg::LQ_BITS-1:0] quotient
);

   localparam int QB = hds_pkg::LQ_BITS;
   localparam int RB = hds_pkg::REM_BITS;

   logic [QB-1:0] lq_ff  [QB+1];
   logic [QB-1:0] lq_in  [QB+1];
   logic [RB-1:0] d_ff   [QB+1];
   logic [RB-1:0] d_in   [QB+1];
   logic [RB-1:0] rem_ff [QB+1];
   logic [RB-1:0] rem_in [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic [QB-1:0] quo_in [QB+1];

   always_comb begin
      logic [QB+7:0] dividend;
      logic [RB:0]   trial;
      int            b;
      lq_in[0]  = log_val;
      d_in[0]   = RB'(density_power) + RB'(256);
      // the top eight dividend bits are below the divisor, so start there
      rem_in[0] = RB'(log_val[QB-1:QB-8]);
      quo_in[0] = '0;
      for (int s = 0; s < QB; s++) begin
         b        = QB - 1 - s;
         dividend = {lq_ff[s], 8'd0};
         trial    = {rem_ff[s], dividend[b]};
         lq_in[s+1] = lq_ff[s];
         d_in[s+1]  = d_ff[s];
         if (trial >= {1'b0, d_ff[s]}) begin
            rem_in[s+1] = RB'(trial - {1'b0, d_ff[s]});
            quo_in[s+1] = quo_ff[s] | (QB'(1) << b);
         end else begin
            rem_in[s+1] = trial[RB-1:0];
            quo_in[s+1] = quo_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq_ff  <= lq_in;
         d_ff   <= d_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff[QB];

endmodule

### rtl/core/hds_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler exp2 unit
// Forms 2^-L' as a product of fixed factors, one multiply a stage, then shifts.
// ----------------------------------------------------------------------------
module hds_exp2 (
   input  logic                        clock,
   input  logic                        en,
   input  logic [hds_pkg::LQ_BITS-1:0] neg_exp,
   output logic [hds_pkg::CQ_BITS-1:0] cos_q
);

   localparam int N  = hds_pkg::FRAC_L;
   localparam int AB = hds_pkg::CQ_BITS;
   localparam int KB = hds_pkg::EXP_K_BITS;
   localparam logic [N-1:0][31:0] EXP_TAB = hds_pkg::exp_table();

   logic [AB-1:0] acc_ff [N+1];
   logic [AB-1:0] acc_in [N+1];
   logic [N-1:0]  f_ff   [N+1];
   logic [N-1:0]  f_in   [N+1];
   logic [KB-1:0] k_ff   [N+1];
   logic [KB-1:0] k_in   [N+1];
   logic [AB-1:0] cos_ff;

   always_comb begin
      logic [AB+31:0] prod;
      logic [AB+31:0] rnd;
      acc_in[0] = AB'(1) << 32;
      f_in[0]   = neg_exp[N-1:0];
      k_in[0]   = neg_exp[hds_pkg::LQ_BITS-1:N];
      for (int s = 0; s < N; s++) begin
         prod = (AB + 32)'(acc_ff[s]) * (AB + 32)'(EXP_TAB[s]);
         rnd  = (prod + ((AB + 32)'(1) << 31)) >> 32;
         f_in[s+1] = f_ff[s];
         k_in[s+1] = k_ff[s];
         acc_in[s+1] = f_ff[s][N-1-s] ? rnd[AB-1:0] : acc_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
         f_ff   <= f_in;
         k_ff   <= k_in;
         cos_ff <= acc_ff[N] >> k_ff[N];
      end
   end

   assign cos_q = cos_ff;

endmodule

### rtl/core/hds_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler sine unit
// sin theta = floor sqrt(2^62 - c^2), square root one result bit a stage.
// ----------------------------------------------------------------------------
module hds_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [31:0]                   cos31,
   output logic [hds_pkg::ROOT_BITS-1:0] sin31
);

   localparam int RB = hds_pkg::ROOT_BITS;

   logic [63:0]   sq_ff;
   logic [63:0]   rem_ff  [RB+1];
   logic [63:0]   rem_in  [RB+1];
   logic [RB-1:0] root_ff [RB+1];
   logic [RB-1:0] root_in [RB+1];

   always_comb begin
      logic [63:0] inc;
      int          b;
      rem_in[0]  = (64'd1 << 62) - sq_ff;
      root_in[0] = '0;
      for (int s = 0; s < RB; s++) begin
         b   = RB - 1 - s;
         // (r + 2^b)^2 - r^2
         inc = (64'(root_ff[s]) << (b + 1)) + (64'd1 << (2 * b));
         if (rem_ff[s] >= inc) begin
            rem_in[s+1]  = rem_ff[s] - inc;
            root_in[s+1] = root_ff[s] | (RB'(1) << b);
         end else begin
            rem_in[s+1]  = rem_ff[s];
            root_in[s+1] = root_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= 64'(cos31) * 64'(cos31);
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign sin31 = root_ff[RB];

endmodule

### rtl/core/hds_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere sampler azimuth unit
// Exact quadrant, then one conditional rotation per bit over two stages each.
// ----------------------------------------------------------------------------
module hds_phase (
   input  logic                            clock,
   input  logic                            en,
   input  logic [hds_pkg::SAMPLE_BITS-1:0] uniform,
   output logic signed [hds_pkg::TRIG_BITS-1:0] cos_phi,
   output logic signed [hds_pkg::TRIG_BITS-1:0] sin_phi
);

   localparam int S  = hds_pkg::PHASE_STEPS;
   localparam int TB = hds_pkg::TRIG_BITS;
   localparam int P  = 2 * S + 1;
   localparam logic [S-1:0][31:0] COS_TAB = hds_pkg::phase_table(1'b0);
   localparam logic [S-1:0][31:0] SIN_TAB = hds_pkg::phase_table(1'b1);
   localparam logic signed [TB-1:0] ONE30 = TB'(1) << 30;

   logic signed [TB-1:0] x_ff    [P];
   logic signed [TB-1:0] x_in    [P];
   logic signed [TB-1:0] y_ff    [P];
   logic signed [TB-1:0] y_in    [P];
   logic [S-1:0]         bits_ff [P];
   logic [S-1:0]         bits_in [P];
   logic signed [63:0]   pxc_ff [S], pxc_in [S];
   logic signed [63:0]   pys_ff [S], pys_in [S];
   logic signed [63:0]   pxs_ff [S], pxs_in [S];
   logic signed [63:0]   pyc_ff [S], pyc_in [S];

   always_comb begin
      logic [1:0] quad;
      logic signed [TB-1:0] c;
      logic signed [TB-1:0] s;
      quad = uniform[hds_pkg::SAMPLE_BITS-1:hds_pkg::SAMPLE_BITS-2];
      unique case (quad)
         2'd0: begin x_in[0] = ONE30;  y_in[0] = '0;     end
         2'd1: begin x_in[0] = '0;     y_in[0] = ONE30;  end
         2'd2: begin x_in[0] = -ONE30; y_in[0] = '0;     end
         2'd3: begin x_in[0] = '0;     y_in[0] = -ONE30; end
         default: begin x_in[0] = '0;  y_in[0] = '0;     end
      endcase
      bits_in[0] = uniform[S-1:0];
      for (int k = 0; k < S; k++) begin
         c = $signed(COS_TAB[k]);
         s = $signed(SIN_TAB[k]);
         // products stage
         pxc_in[k] = x_ff[2*k] * c;
         pys_in[k] = y_ff[2*k] * s;
         pxs_in[k] = x_ff[2*k] * s;
         pyc_in[k] = y_ff[2*k] * c;
         x_in[2*k+1]    = x_ff[2*k];
         y_in[2*k+1]    = y_ff[2*k];
         bits_in[2*k+1] = bits_ff[2*k];
         // sum and round stage
         bits_in[2*k+2] = bits_ff[2*k+1];
         if (bits_ff[2*k+1][S-1-k]) begin
            x_in[2*k+2] = TB'(hds_pkg::rshift_round(pxc_ff[k] - pys_ff[k], 30));
            y_in[2*k+2] = TB'(hds_pkg::rshift_round(pxs_ff[k] + pyc_ff[k], 30));
         end else begin
            x_in[2*k+2] = x_ff[2*k+1];
            y_in[2*k+2] = y_ff[2*k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         bits_ff <= bits_in;
         pxc_ff  <= pxc_in;
         pys_ff  <= pys_in;
         pxs_ff  <= pxs_in;
         pyc_ff  <= pyc_in;
      end
   end

   assign cos_phi = x_ff[P-1];
   assign sin_phi = y_ff[P-1];

endmodule

### rtl/core/hemisphere_direction_sampler.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; the log2 squaring chain,
// the divider and the square root are fully pipelined, one step per stage.
// A stalled output holds the pipeline only while its last stage holds an item.
// Reset clears the valid bits and sets mode to uniform and density_power to 256.
// ----------------------------------------------------------------------------
// Hemisphere direction sampler
// Maps two uniform fractions to a unit direction on the upper hemisphere.
// ----------------------------------------------------------------------------
module hemisphere_direction_sampler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hds_pkg::req_payload_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hds_pkg::rsp_payload_type               rsp_payload,
   input  logic                                   csr_write_en,
   input  logic [hds_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [hds_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int SB          = hds_pkg::SAMPLE_BITS;
   localparam int U_DEPTH     = hds_pkg::LOG_LAT + hds_pkg::DIV_LAT + hds_pkg::EXP_LAT;
   localparam int CQ_POS      = U_DEPTH + 1;
   localparam int ROOT_POS    = CQ_POS + hds_pkg::SQRT_LAT;
   localparam int V_DEPTH     = ROOT_POS - hds_pkg::PHASE_LAT;
   localparam int PRE_POS     = ROOT_POS + 1;
   localparam int DY_DEPTH    = PRE_POS - CQ_POS;
   localparam int VALID_DEPTH = PRE_POS;

   logic                              mode_ff;
   logic [15:0]                       density_power_ff;
   logic [VALID_DEPTH-1:0]            valid_ff;
   logic                              rsp_valid_ff;
   hds_pkg::rsp_payload_type          rsp_payload_ff;
   logic                              out_free;
   logic                              en;

   logic [hds_pkg::FRAC_L-1:0]        log_frac;
   logic [hds_pkg::MSB_BITS-1:0]      log_msb;
   logic [hds_pkg::LQ_BITS-1:0]       log_val;
   logic [hds_pkg::LQ_BITS-1:0]       neg_exp;
   logic [hds_pkg::CQ_BITS-1:0]       exp_cos;
   logic [SB-1:0]                     u_late;
   logic [SB-1:0]                     v_late;
   logic [hds_pkg::CQ_BITS-1:0]       cq_in;
   logic [hds_pkg::CQ_BITS-1:0]       cq_ff;
   logic [31:0]                       cos31;
   logic [hds_pkg::CQ_BITS:0]         y_sum;
   logic [14:0]                       dy_in;
   logic [14:0]                       dy_late;
   logic [hds_pkg::ROOT_BITS-1:0]     sin31;
   logic signed [hds_pkg::TRIG_BITS-1:0] cos_phi;
   logic signed [hds_pkg::TRIG_BITS-1:0] sin_phi;
   logic signed [63:0]                px_ff;
   logic signed [63:0]                pz_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= 1'b0;
         density_power_ff <= hds_pkg::DENSITY_POWER_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            hds_pkg::CSR_MODE:          mode_ff          <= csr_wdata[0];
            hds_pkg::CSR_DENSITY_POWER: density_power_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // the pipeline moves when the output register is free or its feeder is empty
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign en        = out_free || !valid_ff[VALID_DEPTH-1];
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[VALID_DEPTH-2:0], req_valid};
      end
   end

   // cos theta, power mode
   hds_log2 u_log2 (
      .clock   (clock),
      .en      (en),
      .uniform (req_payload.first_uniform),
      .frac    (log_frac),
      .msb_pos (log_msb)
   );

   assign log_val = ((hds_pkg::LQ_BITS'(SB) - hds_pkg::LQ_BITS'(log_msb)) << hds_pkg::FRAC_L)
                    - hds_pkg::LQ_BITS'(log_frac);

   hds_div u_div (
      .clock         (clock),
      .en            (en),
      .log_val       (log_val),
      .density_power (density_power_ff),
      .quotient      (neg_exp)
   );

   hds_exp2 u_exp2 (
      .clock   (clock),
      .en      (en),
      .neg_exp (neg_exp),
      .cos_q   (exp_cos)
   );

   hds_delay #(.WIDTH(SB), .DEPTH(U_DEPTH)) u_u_delay (
      .clock (clock),
      .en    (en),
      .din   (req_payload.first_uniform),
      .dout  (u_late)
   );

   hds_delay #(.WIDTH(SB), .DEPTH(V_DEPTH)) u_v_delay (
      .clock (clock),
      .en    (en),
      .din   (req_payload.second_uniform),
      .dout  (v_late)
   );

   // mode select; a zero fraction in power mode gives cos theta of zero
   always_comb begin
      if (!mode_ff) begin
         cq_in = hds_pkg::CQ_BITS'(u_late) << (32 - SB);
      end else if (u_late == '0) begin
         cq_in = '0;
      end else begin
         cq_in = exp_cos;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cq_ff <= cq_in;
      end
   end

   assign cos31 = 32'((cq_ff + hds_pkg::CQ_BITS'(1)) >> 1);
   assign y_sum = (hds_pkg::CQ_BITS + 1)'(cq_ff) + (hds_pkg::CQ_BITS + 1)'(1 << 16);
   assign dy_in = ((y_sum >> 17) > (hds_pkg::CQ_BITS + 1)'(32767)) ? 15'h7fff
                  : 15'(y_sum >> 17);

   hds_delay #(.WIDTH(15), .DEPTH(DY_DEPTH)) u_dy_delay (
      .clock (clock),
      .en    (en),
      .din   (dy_in),
      .dout  (dy_late)
   );

   hds_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .cos31 (cos31),
      .sin31 (sin31)
   );

   hds_phase u_phase (
      .clock   (clock),
      .en      (en),
      .uniform (v_late),
      .cos_phi (cos_phi),
      .sin_phi (sin_phi)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= $signed({1'b0, sin31}) * cos_phi;
         pz_ff <= $signed({1'b0, sin31}) * sin_phi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= valid_ff[VALID_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_payload_ff.dir_x <= hds_pkg::clamp16(hds_pkg::rshift_round(px_ff, 46));
         rsp_payload_ff.dir_y <= dy_late;
         rsp_payload_ff.dir_z <= hds_pkg::clamp16(hds_pkg::rshift_round(pz_ff, 46));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### dv/hemisphere_direction_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere direction sampler testbench
// Drives uniform pairs through the valid/ready request channel under several
// mode and exponent settings, predicts each direction in fixed point and
// checks every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module hemisphere_direction_sampler_tb;

   localparam int LATENCY = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hds_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hds_pkg::rsp_payload_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic [hds_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [hds_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   hemisphere_direction_sampler i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the registers
   logic        power_mode = 1'b0;
   logic [15:0] exponent_q88 = hds_pkg::DENSITY_POWER_RESET;

   hds_pkg::rsp_payload_type directions_due[$];
   int          error_count = 0;
   int          hold_off = 0;   // long receiver stall, in cycles
   bit          stim_done = 1'b0;

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint round_shift(input longint p, input int sh);
      longint unsigned m;
      m = (p < 0) ? -p : p;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [15:0] sat16(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [63:0] powered_cos(input logic [63:0] u);
      int n;
      logic [63:0] m, frac, lq, lp, k, f, acc, t;
      n = 0;
      frac = 0;
      if (u == 0) return 0;
      while (n < 63 && (u >> (n + 1)) != 0) n++;
      m = u << (31 - n);
      for (int i = 0; i < hds_pkg::FRAC_L; i++) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac[hds_pkg::FRAC_L-1-i] = 1'b1;
         end
      end
      lq = (64'(hds_pkg::SAMPLE_BITS - n) << hds_pkg::FRAC_L) - frac;
      lp = (lq << 8) / (64'(exponent_q88) + 64'd256);
      k = lp >> hds_pkg::FRAC_L;
      f = lp & ((64'd1 << hds_pkg::FRAC_L) - 1);
      acc = 64'd1 << 32;
      t = 64'd1 << 31;
      for (int j = hds_pkg::FRAC_L - 1; j >= 0; j--) begin
         t = root64(t << 32);
         if (f[j]) acc = (acc * t + (64'd1 << 31)) >> 32;
      end
      if (k >= 33) return 0;
      return acc >> k;
   endfunction

   function automatic hds_pkg::rsp_payload_type predict_direction(
      input hds_pkg::req_payload_type r);
      logic [63:0] u, v, cq, c31, s31, y;
      longint x, z, c, s, cn, nx, nz, dx, dz;
      hds_pkg::rsp_payload_type o;
      u = r.first_uniform;
      v = r.second_uniform;
      cq = power_mode ? powered_cos(u) : (u << (32 - hds_pkg::SAMPLE_BITS));
      c31 = (cq + 1) >> 1;
      s31 = root64((64'd1 << 62) - c31 * c31);
      x = (v[15:14] == 2'd0) ? (64'sd1 << 30) : (v[15:14] == 2'd2) ? -(64'sd1 << 30) : 0;
      z = (v[15:14] == 2'd1) ? (64'sd1 << 30) : (v[15:14] == 2'd3) ? -(64'sd1 << 30) : 0;
      c = root64(64'd1 << 59);
      s = c;
      for (int i = hds_pkg::SAMPLE_BITS - 3; i >= 0; i--) begin
         if (v[i]) begin
            nx = round_shift(x * c - z * s, 30);
            nz = round_shift(x * s + z * c, 30);
            x = nx;
            z = nz;
         end
         if (i > 0) begin
            cn = root64(64'((64'sd1 << 30) + c) << 29);
            s = (64'(s) << 29) / 64'(cn);
            c = cn;
         end
      end
      dx = round_shift(longint'(s31) * x, 46);
      dz = round_shift(longint'(s31) * z, 46);
      y = (cq + (64'd1 << 16)) >> 17;
      if (y > 32767) y = 32767;
      o.dir_x = sat16(dx);
      o.dir_y = y[14:0];
      o.dir_z = sat16(dz);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // response checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (directions_due.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            hds_pkg::rsp_payload_type w;
            w = directions_due.pop_front();
            if (rsp_payload.dir_x !== w.dir_x)
               report_mismatch("dir_x", rsp_payload.dir_x, w.dir_x);
            if (rsp_payload.dir_y !== w.dir_y)
               report_mismatch("dir_y", rsp_payload.dir_y, w.dir_y);
            if (rsp_payload.dir_z !== w.dir_z)
               report_mismatch("dir_z", rsp_payload.dir_z, w.dir_z);
         end
      end
   end

   // receiver stall pattern, with long hold-offs on request
   always @(negedge clock) begin
      int phase_cnt;
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         phase_cnt = $urandom_range(0, 15);
         rsp_ready <= (phase_cnt < 4) ? 1'b0 : (phase_cnt < 12) ? 1'b1 : $urandom_range(0, 1);
      end
   end

   task automatic wait_idle();
      while (directions_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hds_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] d);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == hds_pkg::CSR_MODE) power_mode = d[0];
      else exponent_q88 = d;
   endtask

   // offer one item from the falling edge until accepted
   task automatic send_item(input hds_pkg::req_payload_type p, input bit burst_gaps);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      directions_due = {directions_due, predict_direction(p)};
      if (burst_gaps && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   typedef struct {
      logic [15:0] first;
      logic [15:0] second;
      bit          known;
      hds_pkg::rsp_payload_type want;
   } stim_row_type;

   stim_row_type directed_rows[] = '{
      '{16'h0000, 16'h0000, 1'b1, '{16'sh7fff, 15'd0, 16'sh0000}},
      '{16'h0000, 16'h4000, 1'b1, '{16'sh0000, 15'd0, 16'sh7fff}},
      '{16'h0000, 16'h8000, 1'b1, '{-16'sh7fff - 1, 15'd0, 16'sh0000}},
      '{16'h0000, 16'hc000, 1'b1, '{16'sh0000, 15'd0, -16'sh7fff - 1}},
      '{16'hffff, 16'hffff, 1'b0, '0},
      '{16'h8000, 16'h2000, 1'b0, '0},
      '{16'h0001, 16'h0001, 1'b0, '0},
      '{16'h5555, 16'haaaa, 1'b0, '0},
      '{16'haaaa, 16'h5555, 1'b0, '0},
      '{16'h7fff, 16'h3fff, 1'b0, '0}
   };

   task automatic run_directed();
      hds_pkg::rsp_payload_type w;
      foreach (directed_rows[i]) begin
         send_item('{directed_rows[i].first, directed_rows[i].second}, 1'b0);
         w = directions_due[$];
         if (directed_rows[i].known && !power_mode && w !== directed_rows[i].want)
            report_mismatch("directed row", i, 0);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      hds_pkg::req_payload_type p;
      for (int i = 0; i < count; i++) begin
         p.first_uniform = $urandom();
         p.second_uniform = $urandom();
         if ($urandom_range(0, 9) == 0) p.first_uniform = $urandom_range(0, 3);
         if ($urandom_range(0, 19) == 0) p.first_uniform = 16'hffff - $urandom_range(0, 3);
         send_item(p, 1'b1);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: uniform mode
      run_directed();
      run_random(150);
      wait_idle();

      // power mode at reset exponent, with a long receiver hold-off
      write_reg(hds_pkg::CSR_MODE, 16'h0001);
      run_directed();
      hold_off = 400;
      run_random(200);
      wait_idle();

      // extremes of the exponent, including junk upper mode bits
      write_reg(hds_pkg::CSR_DENSITY_POWER, 16'h0000);
      run_random(120);
      wait_idle();
      write_reg(hds_pkg::CSR_DENSITY_POWER, 16'hffff);
      run_directed();
      run_random(120);
      wait_idle();
      write_reg(hds_pkg::CSR_DENSITY_POWER, 16'h0100 + 16'($urandom_range(0, 3000)));
      run_random(150);
      wait_idle();
      write_reg(hds_pkg::CSR_MODE, 16'hfffe);   // bit 0 clear: back to uniform
      run_random(100);
      wait_idle();
      write_reg(hds_pkg::CSR_MODE, 16'h0001);
      write_reg(hds_pkg::CSR_DENSITY_POWER, 16'($urandom()));
      run_random(100);
      wait_idle();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### hemisphere_direction_sampler.f
rtl/core/hds_pkg.sv
rtl/core/hds_delay.sv
rtl/core/hds_log2.sv
rtl/core/hds_div.sv
rtl/core/hds_exp2.sv
rtl/core/hds_sqrt.sv
rtl/core/hds_phase.sv
rtl/core/hemisphere_direction_sampler.sv
dv/hemisphere_direction_sampler_tb.sv
